// ===== rtl/cfd_pkg.sv =====
// Shared types and constants for the centroid frame deframer.
// Used by cfd_ctrl, cfd_dp and centroid_frame_deframer; depends on nothing.
`default_nettype none

package cfd_pkg;

  localparam int CFD_MAX_RECORDS = 16;
  localparam int CFD_IDX_W       = $clog2(CFD_MAX_RECORDS);
  localparam int CFD_CNT_W       = 5;
  localparam int CFD_REC_BYTES   = 6;
  localparam int CFD_MIN_COUNT   = 2;
  localparam int CFD_MAX_COUNT   = 16;

  localparam logic [2:0] CFD_LAST_BYTE = 3'(CFD_REC_BYTES - 1);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;       // Head byte seen: restart framing.
    logic take_count;  // Latch the record count.
    logic take_data;   // Shift in one record byte.
    logic load_out;    // Move the current store entry to the output register.
  } cfd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_head;
    logic count_ok;
    logic rec_end;
    logic frame_end;
    logic drain_last;
    logic out_free;
  } cfd_sts_t;

endpackage

`default_nettype wire

// ===== rtl/centroid_frame_deframer.sv =====
// Centroid frame deframer, top level.
// Byte input channel (in_valid/in_ready/in_rx_byte) carries link bytes; each
// completed frame yields one beat per record on the out_ channel.
// cfg_wr_en/cfg_wr_data set the head byte; write it only while idle.
// Framing: head byte, record count (2..16), then six bytes per record
// (x, y, mass, high byte first). A head byte anywhere restarts the frame.
// Bytes are taken one per cycle while a frame is being received.
// On the last byte of a frame, input stalls while the 16-entry record store
// drains: each record goes through a store read, then an output load, and
// in_ready stays low until the last record of the frame is loaded.
// The output register holds its beat while out_ready is low, and the drain
// simply waits for it; no record is lost.
// Reset is synchronous on rst_n: framing goes idle, the head byte is zero,
// in_ready rises the cycle after reset is released. The store needs no
// clearing, since each record is written before it is read.
`default_nettype none

module centroid_frame_deframer import cfd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_pos_x,
  output logic [15:0]      out_pos_y,
  output logic [15:0]      out_mass,
  output logic [3:0]       out_record_index,
  output logic [4:0]       out_record_total,
  output logic             out_last_record
);

  cfd_cmd_t cmd;
  cfd_sts_t sts;

  cfd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cfd_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_rx_byte       (in_rx_byte),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y),
    .out_mass         (out_mass),
    .out_record_index (out_record_index),
    .out_record_total (out_record_total),
    .out_last_record  (out_last_record)
  );

`ifndef NO_ASSERTIONS
  // The last flag marks exactly the final record of a frame.
  a_last_matches_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_record == ((5'(out_record_index) + 5'd1) == out_record_total)))
    else $error("last_record disagrees with record index and total");

  // A record is only ever emitted for a legal frame size.
  a_total_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_record_total >= 5'(CFD_MIN_COUNT) &&
                   out_record_total <= 5'(CFD_MAX_COUNT)))
    else $error("record_total out of range");

  // Input is never taken while the store is being drained.
  a_no_input_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_out) |-> !in_ready)
    else $error("input accepted during drain");
`endif

endmodule

`default_nettype wire

// ===== rtl/cfd_ctrl.sv =====
// Framing and drain controller for the centroid frame deframer.
// Depends on cfd_pkg for the command and status structs.
`default_nettype none

module cfd_ctrl import cfd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire cfd_sts_t sts,
  output cfd_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_COUNT,
    S_DATA,
    S_RD,
    S_LOAD
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;
  logic   beat;

  assign in_ready = in_ready_r;
  assign beat     = in_valid && in_ready_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    if (beat && sts.is_head) begin
      cmd.clear = 1'b1;
      state_nxt = S_COUNT;
    end else begin
      case (state_r)
        S_IDLE: begin
          state_nxt = S_IDLE;
        end
        S_COUNT: begin
          if (beat) begin
            if (sts.count_ok) begin
              cmd.take_count = 1'b1;
              state_nxt      = S_DATA;
            end else begin
              state_nxt = S_IDLE;
            end
          end
        end
        S_DATA: begin
          if (beat) begin
            cmd.take_data = 1'b1;
            if (sts.rec_end && sts.frame_end) begin
              state_nxt = S_RD;
            end
          end
        end
        S_RD: begin
          state_nxt = S_LOAD;
        end
        S_LOAD: begin
          if (sts.out_free) begin
            cmd.load_out = 1'b1;
            state_nxt    = sts.drain_last ? S_IDLE : S_RD;
          end
        end
        default: begin
          state_nxt = S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_nxt = (state_nxt == S_IDLE) || (state_nxt == S_COUNT) ||
                        (state_nxt == S_DATA);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cfd_dp.sv =====
// Datapath of the centroid frame deframer: head register, record assembly,
// record store and output register. Depends on cfd_pkg.
`default_nettype none

module cfd_dp import cfd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  input  wire logic [7:0]  in_rx_byte,
  input  wire cfd_cmd_t    cmd,
  output cfd_sts_t         sts,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_pos_x,
  output logic [15:0]      out_pos_y,
  output logic [15:0]      out_mass,
  output logic [3:0]       out_record_index,
  output logic [4:0]       out_record_total,
  output logic             out_last_record
);

  logic [7:0]           head_r;
  logic [CFD_CNT_W-1:0] expected_r;
  logic [CFD_CNT_W-1:0] done_r;
  logic [2:0]           bidx_r;
  logic [39:0]          partial_r;
  logic [CFD_IDX_W-1:0] rd_idx_r;
  logic [47:0]          rdata_r;
  logic [47:0]          store_r [CFD_MAX_RECORDS];

  logic                 out_valid_r;
  logic [47:0]          out_rec_r;
  logic [3:0]           out_index_r;
  logic [4:0]           out_total_r;
  logic                 out_last_r;
  logic                 rd_last;

  assign rd_last = ({1'b0, rd_idx_r} + 5'd1) == expected_r;

  assign sts.is_head    = (in_rx_byte == head_r);
  assign sts.count_ok   = (in_rx_byte >= 8'(CFD_MIN_COUNT)) &&
                          (in_rx_byte <= 8'(CFD_MAX_COUNT)) &&
                          (in_rx_byte <= 8'(CFD_MAX_RECORDS));
  assign sts.rec_end    = (bidx_r == CFD_LAST_BYTE);
  assign sts.frame_end  = (done_r + 5'd1) == expected_r;
  assign sts.drain_last = rd_last;
  assign sts.out_free   = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= 8'd0;
      expected_r <= '0;
      done_r     <= '0;
      bidx_r     <= 3'd0;
      rd_idx_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        head_r <= cfg_wr_data;
      end
      if (cmd.clear) begin
        expected_r <= '0;
        done_r     <= '0;
        bidx_r     <= 3'd0;
      end else if (cmd.take_count) begin
        expected_r <= in_rx_byte[CFD_CNT_W-1:0];
        done_r     <= '0;
        bidx_r     <= 3'd0;
        rd_idx_r   <= '0;
      end else if (cmd.take_data) begin
        if (bidx_r == CFD_LAST_BYTE) begin
          done_r <= done_r + 5'd1;
          bidx_r <= 3'd0;
        end else begin
          bidx_r <= bidx_r + 3'd1;
        end
      end else if (cmd.load_out) begin
        rd_idx_r <= rd_idx_r + CFD_IDX_W'(1);
      end
    end
  end

  // Record assembly and store; no reset needed on payload.
  always_ff @(posedge clk) begin
    if (cmd.take_data) begin
      if (bidx_r == CFD_LAST_BYTE) begin
        store_r[done_r[CFD_IDX_W-1:0]] <= {partial_r, in_rx_byte};
      end else begin
        partial_r <= {partial_r[31:0], in_rx_byte};
      end
    end
    rdata_r <= store_r[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_rec_r   <= rdata_r;
      out_index_r <= 4'(rd_idx_r);
      out_total_r <= expected_r;
      out_last_r  <= rd_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pos_x        = out_rec_r[47:32];
  assign out_pos_y        = out_rec_r[31:16];
  assign out_mass         = out_rec_r[15:0];
  assign out_record_index = out_index_r;
  assign out_record_total = out_total_r;
  assign out_last_record  = out_last_r;

endmodule

`default_nettype wire
